### rtl/seeded_region_grow_top_macros.svh
// Assertion macros used by the seeded region grow RTL.
`ifndef SEEDED_REGION_GROW_TOP_MACROS_SVH
`define SEEDED_REGION_GROW_TOP_MACROS_SVH

// Checked property, ignored while reset is asserted.
`define SRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, active during reset as well.
`define SRG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/srg_pkg.sv
// Shared constants, codes and command types of the seeded region grow block.
package srg_pkg;

  localparam int IMAGE_WIDTH  = 320;
  localparam int IMAGE_HEIGHT = 240;
  localparam int PIXELS       = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int PIX_W        = $clog2(PIXELS);
  localparam int ROW_W        = 8;
  localparam int COL_W        = 9;
  localparam int GRAY_W       = 8;
  localparam int SROW_W       = $clog2(IMAGE_HEIGHT + 1);
  localparam int SCOL_W       = $clog2(IMAGE_WIDTH + 2);
  localparam int LB_AW        = $clog2(IMAGE_WIDTH);
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;

  localparam logic [7:0] THR_RESET  = 8'd127;
  localparam logic [7:0] PASS_RESET = 8'd130;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_SEED = 2'd1,
    CMD_GROW = 2'd2,
    CMD_READ = 2'd3
  } cmd_code_t;

  typedef enum logic [0:0] {
    REG_THRESHOLD  = 1'b0,
    REG_PASS_COUNT = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LOAD,
    DP_SEED,
    DP_READ,
    DP_SCAN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   scan_init;
    logic   res_load;
    logic   res_read;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_end;
    logic pass_end;
  } dp_stat_t;

endpackage

### rtl/seeded_region_grow_top.sv
// Top level of the seeded region grow block: channels, configuration and wiring.
//
//  channel | direction | contents
//  in_     | request   | tuser: cmd; tdata: row, col, gray_value
//  out_    | result    | tuser: is_read_reply; tdata: region_bit
//  cfg_    | register  | gray_threshold at 0x0, pass_count at 0x4
//
// Load and seed requests load the result register when accepted; a read request loads it from
// the read state. A grow request runs pass_count passes of (IMAGE_HEIGHT + 1) * (IMAGE_WIDTH + 2)
// positions, the raster walk visiting one pixel position per cycle through the region store.
// After reset the region store is cleared one pixel per cycle over all IMAGE_WIDTH * IMAGE_HEIGHT
// pixels, and no request is accepted until that is done.
// A result waits in the output register; the next request is accepted in the cycle it is taken.
module seeded_region_grow_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // row [7:0], col [16:8], gray_value [24:17]
  input  logic [1:0]                  in_tuser,   // cmd [1:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // region_bit [0]
  output logic [0:0]                  out_tuser,  // is_read_reply [0]
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [srg_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [srg_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [srg_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import srg_pkg::*;

  logic [7:0] gray_threshold;
  logic [7:0] pass_count;
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       res_bit;
  logic       res_read;

  srg_regs u_regs (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .gray_threshold (gray_threshold),
    .pass_count     (pass_count)
  );

  srg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (cmd_code_t'(in_tuser)),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .pass_count (pass_count),
    .stat       (stat),
    .cmd        (cmd)
  );

  srg_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_row         (in_tdata[7:0]),
    .in_col         (in_tdata[16:8]),
    .in_gray        (in_tdata[24:17]),
    .gray_threshold (gray_threshold),
    .res_bit        (res_bit),
    .res_read       (res_read)
  );

  assign out_tdata = {7'b0, res_bit};
  assign out_tuser = res_read;

endmodule

### rtl/srg_regs.sv
// Configuration register file with its APB-style access port.
module srg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [srg_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [srg_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [srg_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  output logic [7:0]                  gray_threshold,
  output logic [7:0]                  pass_count
);
  import srg_pkg::*;

  logic       wr_en;
  reg_index_t idx;
  logic [7:0] thr_r;
  logic [7:0] pass_r;

  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = reg_index_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      pass_r <= PASS_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_THRESHOLD:  thr_r  <= cfg_pwdata[7:0];
        REG_PASS_COUNT: pass_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD:  cfg_prdata = {{(CFG_DW-8){1'b0}}, thr_r};
      REG_PASS_COUNT: cfg_prdata = {{(CFG_DW-8){1'b0}}, pass_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign gray_threshold = thr_r;
  assign pass_count     = pass_r;

endmodule

### rtl/srg_dp.sv
// Datapath: gray and region stores, raster walker, growth window and result register.
module srg_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  srg_pkg::dp_cmd_t            cmd,
  output srg_pkg::dp_stat_t           stat,
  input  logic [srg_pkg::ROW_W-1:0]   in_row,
  input  logic [srg_pkg::COL_W-1:0]   in_col,
  input  logic [srg_pkg::GRAY_W-1:0]  in_gray,
  input  logic [7:0]                  gray_threshold,
  output logic                        res_bit,
  output logic                        res_read
);
  import srg_pkg::*;

  logic [GRAY_W-1:0] gray_mem [PIXELS];
  logic              region_mem [PIXELS];
  logic              line_mem [IMAGE_WIDTH];

  logic [PIX_W-1:0]  in_addr;
  logic              in_inside;

  logic [SROW_W-1:0] row_r;
  logic [SCOL_W-1:0] col_r;
  logic [PIX_W-1:0]  row_base_r;
  logic [PIX_W-1:0]  prev_base_r;
  logic [PIX_W-1:0]  clr_idx_r;
  logic [PIX_W-1:0]  scan_addr_a;
  logic [PIX_W-1:0]  scan_addr_b;

  logic              s1_valid_r;
  logic [SROW_W-1:0] s1_row_r;
  logic [SCOL_W-1:0] s1_col_r;
  logic [PIX_W-1:0]  s1_addr_b_r;

  logic [GRAY_W-1:0] gray_a_q;
  logic [GRAY_W-1:0] gray_b_q;
  logic              region_q;
  logic              line_q;

  logic              pw0_r, pw1_r, cm1_r, cm2_r;
  logic              pw2, lt_a, lt_b, cur_in, m_cur, fin_we, m_end;

  logic              reg_we;
  logic [PIX_W-1:0]  reg_waddr;
  logic              reg_wdata;
  logic [PIX_W-1:0]  reg_raddr;
  logic [LB_AW-1:0]  lb_waddr;

  logic              rd_in_r;
  logic              res_bit_r;
  logic              res_read_r;

  assign in_addr   = PIX_W'(in_row) * PIX_W'(IMAGE_WIDTH) + PIX_W'(in_col);
  assign in_inside = (32'(in_row) < IMAGE_HEIGHT) && (32'(in_col) < IMAGE_WIDTH);

  // The walker column runs one step ahead of and one step past the image row.
  assign scan_addr_a = row_base_r + PIX_W'(col_r) - PIX_W'(1);
  assign scan_addr_b = prev_base_r + PIX_W'(col_r) - PIX_W'(2);

  assign stat.pass_end  = (cmd.op == DP_SCAN) && (row_r == SROW_W'(IMAGE_HEIGHT)) &&
                          (col_r == SCOL_W'(IMAGE_WIDTH + 1));
  assign stat.clear_end = (clr_idx_r == PIX_W'(PIXELS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      row_base_r  <= '0;
      prev_base_r <= '0;
      clr_idx_r   <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= (cmd.op == DP_SCAN);
      if (cmd.op == DP_CLEAR) begin
        clr_idx_r <= clr_idx_r + PIX_W'(1);
      end
      if (cmd.scan_init) begin
        row_r       <= '0;
        col_r       <= '0;
        row_base_r  <= '0;
        prev_base_r <= '0;
      end else if (cmd.op == DP_SCAN) begin
        if (col_r == SCOL_W'(IMAGE_WIDTH + 1)) begin
          col_r       <= '0;
          row_r       <= row_r + SROW_W'(1);
          prev_base_r <= row_base_r;
          row_base_r  <= row_base_r + PIX_W'(IMAGE_WIDTH);
        end else begin
          col_r <= col_r + SCOL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_row_r    <= row_r;
    s1_col_r    <= col_r;
    s1_addr_b_r <= scan_addr_b;
  end

  // Stage one: current pixel mark and final mark of the pixel up and to the left.
  assign lt_a   = (gray_a_q < gray_threshold);
  assign lt_b   = (gray_b_q < gray_threshold);
  assign pw2    = (s1_row_r != '0) && (s1_col_r < SCOL_W'(IMAGE_WIDTH)) && line_q;
  assign cur_in = s1_valid_r && (s1_col_r != '0) && (s1_col_r <= SCOL_W'(IMAGE_WIDTH)) &&
                  (s1_row_r < SROW_W'(IMAGE_HEIGHT));
  assign m_cur  = cur_in && (region_q || (lt_a && (pw0_r || pw1_r || pw2 || cm1_r)));
  assign fin_we = s1_valid_r && (s1_row_r != '0) && (s1_col_r >= SCOL_W'(2));
  assign m_end  = pw0_r || (lt_b && (pw1_r || cm2_r || cm1_r || m_cur));
  assign lb_waddr = LB_AW'(s1_col_r - SCOL_W'(1));

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      pw1_r <= pw2;
      if (s1_col_r == '0) begin
        pw0_r <= 1'b0;
        cm1_r <= 1'b0;
        cm2_r <= 1'b0;
      end else begin
        pw0_r <= pw1_r;
        cm2_r <= cm1_r;
        cm1_r <= m_cur;
      end
    end
  end

  always_comb begin
    case (cmd.op)
      DP_CLEAR: begin
        reg_we    = 1'b1;
        reg_waddr = clr_idx_r;
        reg_wdata = 1'b0;
      end
      DP_LOAD: begin
        reg_we    = in_inside;
        reg_waddr = in_addr;
        reg_wdata = 1'b0;
      end
      DP_SEED: begin
        reg_we    = in_inside;
        reg_waddr = in_addr;
        reg_wdata = 1'b1;
      end
      default: begin
        reg_we    = fin_we;
        reg_waddr = s1_addr_b_r;
        reg_wdata = m_end;
      end
    endcase
  end

  assign reg_raddr = (cmd.op == DP_SCAN) ? scan_addr_a : in_addr;

  always_ff @(posedge clk) begin
    if ((cmd.op == DP_LOAD) && in_inside) begin
      gray_mem[in_addr] <= in_gray;
    end
    gray_a_q <= gray_mem[scan_addr_a];
    gray_b_q <= gray_mem[scan_addr_b];
  end

  always_ff @(posedge clk) begin
    if (reg_we) begin
      region_mem[reg_waddr] <= reg_wdata;
    end
    region_q <= region_mem[reg_raddr];
  end

  always_ff @(posedge clk) begin
    if (cur_in) begin
      line_mem[lb_waddr] <= m_cur;
    end
    line_q <= line_mem[LB_AW'(col_r)];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_READ) begin
      rd_in_r <= in_inside;
    end
    if (cmd.res_load) begin
      res_bit_r  <= cmd.res_read && rd_in_r && region_q;
      res_read_r <= cmd.res_read;
    end
  end

  assign res_bit  = res_bit_r;
  assign res_read = res_read_r;

endmodule

### rtl/srg_ctrl.sv
// Controller: request sequencing, pass counting and result handshake.
`include "seeded_region_grow_top_macros.svh"

module srg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  srg_pkg::cmd_code_t  in_cmd,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  logic [7:0]          pass_count,
  input  srg_pkg::dp_stat_t   stat,
  output srg_pkg::dp_cmd_t    cmd
);
  import srg_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_GROW,
    ST_DRAIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [7:0] pass_left_r, pass_left_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    pass_left_nxt = pass_left_r;
    cmd.op        = DP_NOP;
    cmd.scan_init = 1'b0;
    cmd.res_load  = 1'b0;
    cmd.res_read  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (stat.clear_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_LOAD: begin
              cmd.op       = DP_LOAD;
              cmd.res_load = 1'b1;
            end
            CMD_SEED: begin
              cmd.op       = DP_SEED;
              cmd.res_load = 1'b1;
            end
            CMD_GROW: begin
              cmd.scan_init = 1'b1;
              if (pass_count == 8'd0) begin
                cmd.res_load = 1'b1;
              end else begin
                pass_left_nxt = pass_count;
                state_nxt     = ST_GROW;
              end
            end
            CMD_READ: begin
              cmd.op    = DP_READ;
              state_nxt = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.res_load = 1'b1;
        cmd.res_read = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_GROW: begin
        cmd.op = DP_SCAN;
        if (stat.pass_end) begin
          cmd.scan_init = 1'b1;
          pass_left_nxt = pass_left_r - 8'd1;
          if (pass_left_r == 8'd1) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        cmd.res_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pass_left_r <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_left_r <= pass_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SRG_ASSERT(a_res_slot_free, cmd.res_load |-> (!out_valid_r || out_tready), "result overwritten while still pending")
  `SRG_ASSERT(a_scan_has_pass, (cmd.op == DP_SCAN) |-> (pass_left_r != 8'd0), "scan step without a pass left")
  `SRG_ASSERT(a_last_pass_drains, ((state_r == ST_GROW) && stat.pass_end && (pass_left_r == 8'd1)) |=> (state_r == ST_DRAIN), "last pass did not drain")

endmodule
